[hw/rtl/amt_pkg.sv]
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types and codes for the ip-to-mac address table: op codes, status
// codes, scan sequencer states and the bundles passed between modules.
// ----------------------------------------------------------------------------
package amt_pkg;

  // operation codes carried on the input channel
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // scan sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } amt_state_t;

  // table write request (index travels on its own port, its width follows ENTRIES)
  typedef struct packed {
    logic        en;
    logic        mac_en;
    logic [31:0] ip;
    logic [47:0] mac;
  } amt_wr_t;

  // one result transaction
  typedef struct packed {
    logic        status;
    logic [47:0] mac;
  } amt_res_t;

endpackage

[hw/rtl/amt_if.sv]
// ----------------------------------------------------------------------------
// amt_in_if / amt_out_if
// Valid/ready channels of the ip-to-mac table: operation requests in,
// status and mac results out.
// ----------------------------------------------------------------------------
interface amt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] ip_addr;
  logic [47:0] mac_addr;

  modport source (output valid, output op, output ip_addr, output mac_addr, input ready);
  modport sink   (input valid, input op, input ip_addr, input mac_addr, output ready);
endinterface

interface amt_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [47:0] mac_out;

  modport source (output valid, output status, output mac_out, input ready);
  modport sink   (input valid, input status, input mac_out, output ready);
endinterface

[hw/rtl/amt_table.sv]
// ----------------------------------------------------------------------------
// amt_table
// Entry storage: ip and mac arrays with one write port and one registered
// read port each. The ip array can be written without the mac array.
// ----------------------------------------------------------------------------
module amt_table #(
  parameter int ENTRIES = 128
) (
  input  logic                                                   clk,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]       rd_idx,
  output logic [31:0]                                            rd_ip,
  output logic [47:0]                                            rd_mac,
  input  amt_pkg::amt_wr_t                                       wr,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]       wr_idx
);
  import amt_pkg::*;

  logic [31:0] ip_mem  [ENTRIES];
  logic [47:0] mac_mem [ENTRIES];
  logic [31:0] rd_ip_r;
  logic [47:0] rd_mac_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      ip_mem[wr_idx] <= wr.ip;
      if (wr.mac_en) begin
        mac_mem[wr_idx] <= wr.mac;
      end
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_ip_r  <= ip_mem[rd_idx];
    rd_mac_r <= mac_mem[rd_idx];
  end

  assign rd_ip  = rd_ip_r;
  assign rd_mac = rd_mac_r;

endmodule

[hw/rtl/amt_scan.sv]
// ----------------------------------------------------------------------------
// amt_scan
// Scan sequencer: clears the table after reset, then runs one operation at a
// time as a pipelined walk over the entries through a single key comparator.
// ----------------------------------------------------------------------------
module amt_scan #(
  parameter int ENTRIES = 128
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   start,
  input  logic [1:0]                                             op,
  input  logic [31:0]                                            key,
  input  logic [47:0]                                            mac,
  output logic                                                   ready,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]       rd_idx,
  input  logic [31:0]                                            rd_ip,
  input  logic [47:0]                                            rd_mac,
  output amt_pkg::amt_wr_t                                       wr,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]       wr_idx,
  output logic                                                   res_valid,
  output amt_pkg::amt_res_t                                      res,
  input  logic                                                   res_ready
);
  import amt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW:0] CNT_END  = (AW + 1)'(ENTRIES);
  localparam logic [AW:0] CNT_LAST = (AW + 1)'(ENTRIES - 1);

  amt_state_t    state_r, state_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [1:0]    op_r;
  logic [31:0]   key_r;
  logic [47:0]   mac_r;
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic [AW-1:0] rd_idx_r;
  amt_res_t      res_r, res_nxt;

  logic ip_eq, ip_free, stop_hit, rm_hit, scan_end, issue;

  // shared comparator on the entry just read
  always_comb begin
    ip_eq    = (rd_ip == key_r);
    ip_free  = (rd_ip == 32'd0);
    stop_hit = 1'b0;
    rm_hit   = 1'b0;
    case (op_r)
      OP_LOOKUP: stop_hit = rd_vld_r && ip_eq;
      OP_ADD:    stop_hit = rd_vld_r && (ip_eq || ip_free);
      OP_REMOVE: rm_hit   = rd_vld_r && ip_eq;
      default:   stop_hit = 1'b0;
    endcase
    scan_end = stop_hit || (rd_vld_r && rd_last_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (cnt_r == CNT_LAST) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = ST_RESP;
      ST_RESP:  if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath control
  always_comb begin
    ready       = 1'b0;
    res_valid   = 1'b0;
    issue       = 1'b0;
    cnt_nxt     = cnt_r;
    wr          = '0;
    wr_idx      = rd_idx_r;
    res_nxt     = res_r;
    case (state_r)
      ST_CLEAR: begin
        wr.en     = 1'b1;
        wr.mac_en = 1'b1;
        wr_idx    = cnt_r[AW-1:0];
        cnt_nxt   = (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
      end
      ST_IDLE: begin
        ready   = 1'b1;
        cnt_nxt = '0;
      end
      ST_SCAN: begin
        issue = !stop_hit && (cnt_r < CNT_END);
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // add writes the claimed entry, remove frees each match
        if (stop_hit && (op_r == OP_ADD)) begin
          wr.en     = 1'b1;
          wr.mac_en = 1'b1;
          wr.ip     = key_r;
          wr.mac    = mac_r;
        end else if (rm_hit) begin
          wr.en = 1'b1;
        end
        if (stop_hit) begin
          res_nxt.status = STATUS_OK;
          res_nxt.mac    = (op_r == OP_LOOKUP) ? rd_mac : 48'd0;
        end else begin
          res_nxt.status = (op_r == OP_REMOVE) ? STATUS_OK : STATUS_FAIL;
          res_nxt.mac    = 48'd0;
        end
      end
      ST_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
    rd_vld_nxt  = issue;
    rd_last_nxt = issue && (cnt_r == CNT_LAST);
  end

  assign rd_idx = cnt_r[AW-1:0];
  assign res    = res_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
    end
  end

  // operation and pipeline payload
  always_ff @(posedge clk) begin
    if (start && ready) begin
      op_r  <= op;
      key_r <= key;
      mac_r <= mac;
    end
    rd_idx_r <= cnt_r[AW-1:0];
    if (state_r == ST_SCAN && scan_end) begin
      res_r <= res_nxt;
    end
  end

endmodule

[hw/rtl/ip_to_mac_table_top.sv]
// ----------------------------------------------------------------------------
// ip_to_mac_table_top
// Address-resolution table mapping 32-bit ip addresses to 48-bit mac
// addresses, with lookup, add-or-replace and remove-all operations.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     payload
//   in_if     in   valid/ready   op[1:0], ip_addr[31:0], mac_addr[47:0]
//   out_if    out  valid/ready   status, mac_out[47:0]
//
// Each operation walks the table one entry per cycle through one comparator, with a
// registered read port and a separate write port; the walk ends at a stopping
// entry or after the last one. After reset the table is cleared with in_if.ready low.
// One operation is in flight at a time; a waiting result sits in the output
// register, so the next operation can be taken while out_if is stalled.
// ----------------------------------------------------------------------------
module ip_to_mac_table_top #(
  parameter int ENTRIES = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  amt_in_if.sink    in_if,
  amt_out_if.source out_if
);
  import amt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          scan_ready;
  logic [AW-1:0] rd_idx;
  logic [31:0]   rd_ip;
  logic [47:0]   rd_mac;
  amt_wr_t       wr;
  logic [AW-1:0] wr_idx;
  logic          res_valid;
  amt_res_t      res;
  logic          res_ready;

  logic          out_valid_r;
  amt_res_t      out_res_r;

  amt_table #(.ENTRIES(ENTRIES)) u_table (
    .clk    (clk),
    .rd_idx (rd_idx),
    .rd_ip  (rd_ip),
    .rd_mac (rd_mac),
    .wr     (wr),
    .wr_idx (wr_idx)
  );

  amt_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_if.valid),
    .op        (in_if.op),
    .key       (in_if.ip_addr),
    .mac       (in_if.mac_addr),
    .ready     (scan_ready),
    .rd_idx    (rd_idx),
    .rd_ip     (rd_ip),
    .rd_mac    (rd_mac),
    .wr        (wr),
    .wr_idx    (wr_idx),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign in_if.ready = scan_ready;

  // output register, refilled when empty or being drained
  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.status  = out_res_r.status;
  assign out_if.mac_out = out_res_r.mac;

`ifndef NO_ASSERTIONS
  // a handed-over result shows up on the output
  a_res_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_if.valid)
    else $error("result handed over but output not valid");

  // an accepted transaction keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input ready right after an accepted transaction");

  // a pending result holds until the output register takes it
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result dropped or changed");

  // no new transaction while a result is waiting for the output register
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_if.ready)
    else $error("input ready while a result is pending");
`endif

endmodule
